>>> hdl/tlfd_pkg.sv
// Package for the three-level feedback dispatcher.
// Holds field widths, register indexes, event codes and reset values.
// No dependencies.
package tlfd_pkg;
    localparam int MaxJobs = 64;
    localparam int IdW = 6;
    localparam int SvcW = 16;
    localparam int SlcW = 8;
    localparam int TickW = 32;
    localparam int CfgW = 16;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] RegL0Quantum = 2'd0;
    localparam logic [CfgIdxW-1:0] RegL1Quantum = 2'd1;
    localparam logic [CfgIdxW-1:0] RegL1Slices  = 2'd2;

    localparam logic [15:0] L0QuantumReset = 16'd4;
    localparam logic [15:0] L1QuantumReset = 16'd8;
    localparam logic [7:0]  L1SlicesReset  = 8'd2;

    localparam logic [2:0] EvNone     = 3'd0;
    localparam logic [2:0] EvDone     = 3'd1;
    localparam logic [2:0] EvToL1     = 3'd2;
    localparam logic [2:0] EvL1Requeue = 3'd3;
    localparam logic [2:0] EvToL2     = 3'd4;
    localparam logic [2:0] EvL2Preempt = 3'd5;

    localparam logic [0:0] OpAdd  = 1'b0;
    localparam logic [0:0] OpTick = 1'b1;
endpackage

>>> hdl/three_level_feedback_dispatcher_unit.sv
// Three-level feedback queue dispatcher, top level; uses tlfd_pkg.
// An add passes through S_ADD and gives no result. A tick passes through S_RD,
// S_EVAL (with a job running), S_POP and S_OUT, its result strobed by o_done for one
// cycle while busy is already low. The receiver cannot stall; a new add or tick is
// accepted only in idle. Synchronous active-low reset clears state, counters, queue
// pointers, the current job, o_done and config; the job table is not cleared.
module three_level_feedback_dispatcher_unit #(
    parameter int MAX_JOBS = tlfd_pkg::MaxJobs
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [tlfd_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [tlfd_pkg::CfgW-1:0]    i_cfg_data,
    input  logic [0:0]  i_op,
    input  logic [5:0]  i_job_id,
    input  logic [15:0] i_service_time,
    output logic        o_done,
    output logic        o_running_valid,
    output logic [5:0]  o_running_job,
    output logic [2:0]  o_event_code,
    output logic [5:0]  o_event_job,
    output logic [31:0] o_turnaround,
    output logic [31:0] o_waiting_time,
    output logic        o_busy_res
);
    localparam int AW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] Full = CW'(MAX_JOBS);
    localparam logic [AW-1:0] LastIdx = AW'(MAX_JOBS - 1);

    // One job-table entry, packed so the table is a single-port memory.
    typedef struct packed {
        logic [15:0] svc;
        logic [15:0] run;
        logic [15:0] slice_t;
        logic [7:0]  slice_n;
        logic [1:0]  lvl;
        logic [31:0] arr;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_RD, S_EVAL, S_POP, S_OUT
    } t_state;

    t_job r_tab [MAX_JOBS];
    logic [5:0] r_fifo [3][MAX_JOBS];
    logic [AW-1:0] r_head [3];
    logic [CW-1:0] r_cnt [3];

    t_state r_state;
    logic [15:0] r_q0, r_q1;
    logic [7:0]  r_ns;
    logic [31:0] r_tick;
    logic [AW-1:0] r_cur;
    logic r_cur_v;
    logic [AW-1:0] r_id;
    logic r_id_ok;
    logic [15:0] r_svc_in;
    t_job r_rd;       // registered table read
    logic [5:0] r_frd; // registered FIFO head read
    logic [1:0] r_plvl;
    logic [2:0] r_ev;
    logic [5:0] r_evj;
    logic [31:0] r_turn;

    // Turnaround: tick minus arrival time of the job read, clamped at zero.
    logic [31:0] w_turn;
    assign w_turn = (r_tick >= r_rd.arr) ? r_tick - r_rd.arr : 32'd0;

    logic [1:0] w_lvl_sel;
    always_comb begin
        priority if (r_cnt[0] != '0) w_lvl_sel = 2'd0;
        else if (r_cnt[1] != '0)     w_lvl_sel = 2'd1;
        else                          w_lvl_sel = 2'd2;
    end
    logic w_any;
    assign w_any = (r_cnt[0] != '0) || (r_cnt[1] != '0) || (r_cnt[2] != '0);

    function automatic logic [AW-1:0] tail(input logic [AW-1:0] h, input logic [CW-1:0] c);
        logic [CW:0] s;
        s = {1'b0, {1'b0, h} + c};
        if (s >= (CW+1)'(MAX_JOBS)) s = s - (CW+1)'(MAX_JOBS);
        return s[AW-1:0];
    endfunction

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q0 <= tlfd_pkg::L0QuantumReset;
            r_q1 <= tlfd_pkg::L1QuantumReset;
            r_ns <= tlfd_pkg::L1SlicesReset;
            r_tick <= '0;
            r_cur <= '0;
            r_cur_v <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_head[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tlfd_pkg::RegL0Quantum: r_q0 <= i_cfg_data;
                    tlfd_pkg::RegL1Quantum: r_q1 <= i_cfg_data;
                    tlfd_pkg::RegL1Slices:  r_ns <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_id <= AW'(i_job_id);
                        r_id_ok <= ({26'd0, i_job_id} < 32'(MAX_JOBS));
                        r_svc_in <= i_service_time;
                        r_state <= (i_op == tlfd_pkg::OpAdd) ? S_ADD : S_RD;
                    end
                end
                S_ADD: begin
                    if (r_id_ok && r_cnt[0] < Full) begin
                        r_tab[r_id] <= '{svc: r_svc_in, run: '0, slice_t: '0,
                                         slice_n: '0, lvl: 2'd0, arr: r_tick};
                        r_fifo[0][tail(r_head[0], r_cnt[0])] <= 6'(r_id);
                        r_cnt[0] <= r_cnt[0] + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_rd <= r_tab[r_cur];
                    r_ev <= tlfd_pkg::EvNone;
                    r_evj <= '0;
                    r_turn <= '0;
                    r_state <= r_cur_v ? S_EVAL : S_POP;
                end
                S_EVAL: begin
                    t_job e;
                    logic [1:0] pq;
                    logic push;
                    e = r_rd;
                    push = 1'b0;
                    pq = 2'd1;
                    r_evj <= 6'(r_cur);
                    r_cur_v <= 1'b0;
                    priority if (r_rd.run >= r_rd.svc || r_rd.svc == 16'd0) begin
                        r_ev <= tlfd_pkg::EvDone;
                        r_turn <= w_turn;
                    end else if (r_rd.lvl == 2'd0 && r_rd.run >= r_q0) begin
                        r_ev <= tlfd_pkg::EvToL1;
                        e.lvl = 2'd1; e.slice_t = '0; push = 1'b1; pq = 2'd1;
                    end else if (r_rd.lvl == 2'd1 && r_rd.slice_n >= r_ns) begin
                        r_ev <= tlfd_pkg::EvToL2;
                        e.lvl = 2'd2; push = 1'b1; pq = 2'd2;
                    end else if (r_rd.lvl == 2'd1 && r_rd.slice_t >= r_q1) begin
                        r_ev <= tlfd_pkg::EvL1Requeue;
                        if (r_rd.slice_n != 8'hFF) e.slice_n = r_rd.slice_n + 8'd1;
                        e.slice_t = '0; push = 1'b1; pq = 2'd1;
                    end else if (r_rd.lvl == 2'd2 &&
                                 (r_cnt[0] != '0 || r_cnt[1] != '0)) begin
                        r_ev <= tlfd_pkg::EvL2Preempt;
                        push = 1'b1; pq = 2'd2;
                    end else begin
                        r_cur_v <= 1'b1;
                        r_evj <= '0;
                        if (r_rd.run != 16'hFFFF) e.run = r_rd.run + 16'd1;
                        if (r_rd.slice_t != 16'hFFFF) e.slice_t = r_rd.slice_t + 16'd1;
                    end
                    r_tab[r_cur] <= e;
                    if (push && r_cnt[pq] < Full) begin
                        r_fifo[pq][tail(r_head[pq], r_cnt[pq])] <= 6'(r_cur);
                        r_cnt[pq] <= r_cnt[pq] + 1'b1;
                    end
                    r_state <= S_POP;
                end
                S_POP: begin
                    // Counts here already include any requeue from evaluation.
                    r_plvl <= (r_cur_v || !w_any) ? 2'd3 : w_lvl_sel;
                    r_frd <= r_fifo[w_lvl_sel][r_head[w_lvl_sel]];
                    o_running_job <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    logic v;
                    logic [AW-1:0] c;
                    v = r_cur_v;
                    c = r_cur;
                    if (r_plvl != 2'd3) begin
                        v = 1'b1;
                        c = AW'(r_frd);
                        r_head[r_plvl] <= (r_head[r_plvl] == LastIdx) ? '0
                                          : r_head[r_plvl] + 1'b1;
                        r_cnt[r_plvl] <= r_cnt[r_plvl] - 1'b1;
                    end
                    r_cur_v <= v;
                    r_cur <= c;
                    if (r_tick != 32'hFFFF_FFFF) r_tick <= r_tick + 32'd1;
                    o_done <= 1'b1;
                    o_running_valid <= v;
                    o_running_job <= v ? 6'(c) : 6'd0;
                    o_event_code <= r_ev;
                    o_event_job <= r_evj;
                    o_turnaround <= r_turn;
                    // The table read is only meaningful when a job completed.
                    o_waiting_time <= (r_ev == tlfd_pkg::EvDone &&
                                       r_turn >= {16'd0, r_rd.svc})
                                      ? r_turn - {16'd0, r_rd.svc} : 32'd0;
                    // Busy result: high while a job runs, else when any queue holds an entry.
                    o_busy_res <= v || (r_plvl != 2'd3 ?
                        ((r_cnt[0] + r_cnt[1] + r_cnt[2]) > CW'(1)) : w_any);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_cnt0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= Full) else $error("level-0 count overflow");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");
    a_ev_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_event_code == tlfd_pkg::EvNone) |-> o_event_job == 6'd0)
        else $error("event slot without event");
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_running_valid) |-> o_busy_res) else $error("busy flag low");
`endif
endmodule
